// File: rtl/core/hlb_pkg.sv
// ----------------------------------------------------------------------------
// hlb_pkg: shared definitions for the hex literal to bytes unit
// Phase codes, the result record and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hlb_pkg;

  // Default width of the per-string byte counter.
  localparam int COUNT_BITS_DEF = 16;

  // Width of the length field in a result.
  localparam int LEN_BITS = 16;

  // Phase of the string being decoded.
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_ZERO    = 3'd1;
  localparam logic [2:0] PH_HEX0    = 3'd2;
  localparam logic [2:0] PH_QUOTE   = 3'd3;
  localparam logic [2:0] PH_HEXQ    = 3'd4;
  localparam logic [2:0] PH_RAW     = 3'd5;
  localparam logic [2:0] PH_NEEDNUL = 3'd6;
  localparam logic [2:0] PH_SKIP    = 3'd7;

  // Characters of interest.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  typedef struct packed {
    logic [7:0]          data;
    logic                data_valid;
    logic                last;
    logic                status;
    logic [LEN_BITS-1:0] total_length;
  } hlb_result_t;

  // Returns {is_digit, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v  = c - CH_ZERO;
      ok = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      v  = c - CH_UP_A + LETTER_OFS;
      ok = 1'b1;
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      v  = c - CH_LOW_A + LETTER_OFS;
      ok = 1'b1;
    end
    return {ok, v[3:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hlb_step.sv
// ----------------------------------------------------------------------------
// hlb_step: per-character decode step
// Works out the next string state and the result, if any, for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module hlb_step #(
  parameter int COUNT_BITS = hlb_pkg::COUNT_BITS_DEF
) (
  input  wire logic [7:0]            ch,
  input  wire logic [2:0]            phase,
  input  wire logic [3:0]            high_nibble,
  input  wire logic                  pending,
  input  wire logic [COUNT_BITS-1:0] count,
  input  wire logic [COUNT_BITS-1:0] limit,
  output logic [2:0]                 phase_nxt,
  output logic [3:0]                 high_nibble_nxt,
  output logic                       pending_nxt,
  output logic [COUNT_BITS-1:0]      count_nxt,
  output logic                       res_valid,
  output hlb_pkg::hlb_result_t       res
);
  import hlb_pkg::*;

  logic [4:0]            dig;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  fin;
  logic                  err;
  logic                  eff_pend;
  logic [3:0]            eff_hn;
  logic                  hex_mode;
  logic                  quoted;
  logic                  at_end;

  assign dig       = hex_digit(ch);
  assign count_inc = count + COUNT_BITS'(1);

  always_comb begin
    phase_nxt       = phase;
    high_nibble_nxt = high_nibble;
    pending_nxt     = pending;
    count_nxt       = count;
    res_valid       = 1'b0;
    res             = '0;
    fin             = 1'b0;
    err             = 1'b0;
    eff_pend        = pending;
    eff_hn          = high_nibble;
    hex_mode        = 1'b0;
    quoted          = 1'b0;
    at_end          = 1'b0;

    unique case (phase)
      PH_START: begin
        if (ch == CH_NUL) begin
          fin = 1'b1;
        end else if (ch == CH_ZERO) begin
          phase_nxt = PH_ZERO;
        end else if (ch == CH_LOW_X || ch == CH_UP_X) begin
          phase_nxt = PH_QUOTE;
        end else begin
          phase_nxt       = PH_RAW;
          count_nxt       = COUNT_BITS'(1);
          res_valid       = 1'b1;
          res.data        = ch;
          res.data_valid  = 1'b1;
        end
      end
      PH_ZERO: begin
        phase_nxt = PH_HEX0;
        if (ch != CH_LOW_X) begin
          // The leading zero stands as a high nibble of zero.
          eff_pend = 1'b1;
          eff_hn   = 4'd0;
          hex_mode = 1'b1;
        end
      end
      PH_HEX0: hex_mode = 1'b1;
      PH_QUOTE: begin
        if (ch == CH_QUOTE) begin
          phase_nxt = PH_HEXQ;
        end else begin
          fin = 1'b1;
          err = 1'b1;
        end
      end
      PH_HEXQ: begin
        hex_mode = 1'b1;
        quoted   = 1'b1;
      end
      PH_RAW: begin
        if (ch == CH_NUL) begin
          fin = 1'b1;
        end else if (count >= limit) begin
          fin = 1'b1;
          err = 1'b1;
        end else begin
          count_nxt      = count_inc;
          res_valid      = 1'b1;
          res.data       = ch;
          res.data_valid = 1'b1;
        end
      end
      PH_NEEDNUL: begin
        fin = 1'b1;
        err = (ch != CH_NUL);
      end
      default: begin
        if (ch == CH_NUL) begin
          phase_nxt = PH_START;
        end
      end
    endcase

    if (hex_mode) begin
      at_end = (ch == CH_NUL) || (quoted && ch == CH_QUOTE);
      if (at_end) begin
        // Flush an odd trailing nibble as a high nibble.
        fin = 1'b1;
        if (eff_pend) begin
          if (count >= limit) begin
            err = 1'b1;
          end else begin
            count_nxt      = count_inc;
            res.data       = {eff_hn, 4'd0};
            res.data_valid = 1'b1;
          end
        end
      end else if (!dig[4]) begin
        fin = 1'b1;
        err = 1'b1;
      end else if (eff_pend) begin
        pending_nxt    = 1'b0;
        count_nxt      = count_inc;
        res_valid      = 1'b1;
        res.data       = {eff_hn, dig[3:0]};
        res.data_valid = 1'b1;
        if (count_inc >= limit) begin
          if (quoted) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_NEEDNUL;
          end
        end
      end else begin
        high_nibble_nxt = dig[3:0];
        pending_nxt     = 1'b1;
      end
    end

    if (fin) begin
      res_valid    = 1'b1;
      res.last     = 1'b1;
      res.status   = err;
      if (err) begin
        res.data       = 8'd0;
        res.data_valid = 1'b0;
      end else begin
        res.total_length = LEN_BITS'(count_nxt);
      end
      phase_nxt       = (ch == CH_NUL) ? PH_START : PH_SKIP;
      high_nibble_nxt = 4'd0;
      pending_nxt     = 1'b0;
      count_nxt       = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hex_literal_to_bytes_unit.sv
// ----------------------------------------------------------------------------
// hex_literal_to_bytes_unit: streaming decoder of SQL-style hex literals
// Flow: a character accepted into the input register is decoded once the result
//   register has room, and its result, if any, is shown there until taken.
// Throughput: one character per cycle while the output is not stalled, set by
//   the single decode step between the input register and the result register.
// Reset (rst_n low, synchronous): both registers empty, string state at the
//   start of a string, byte limit 65535 (capped at the counter's range).
// ----------------------------------------------------------------------------
`default_nettype none

module hex_literal_to_bytes_unit #(
  parameter int COUNT_BITS = hlb_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Character requests.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   in_char,
  // Result requests.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [7:0]                        out_byte,
  output logic                              out_byte_valid,
  output logic                              out_last,
  output logic                              out_status,
  output logic [hlb_pkg::LEN_BITS-1:0]      out_total_length,
  // Byte limit register write.
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [15:0]                  cfg_data
);
  import hlb_pkg::*;

  // Greatest value the byte counter can hold, and the limit after reset.
  localparam logic [32:0] CAP       = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic [32:0] RST_LIMIT = (CAP < 33'd65535) ? CAP : 33'd65535;

  // Input register: one character waiting for the decode step.
  logic                  in_valid_r;
  logic [7:0]            in_char_r;

  // String state.
  logic [2:0]            phase_r;
  logic [3:0]            high_nibble_r;
  logic                  pending_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [2:0]            phase_nxt;
  logic [3:0]            high_nibble_nxt;
  logic                  pending_nxt;
  logic [COUNT_BITS-1:0] count_nxt;

  // Effective byte limit, already clamped to one and to the counter range.
  logic [COUNT_BITS-1:0] limit_r;
  logic [COUNT_BITS-1:0] limit_nxt;
  logic [32:0]           cfg_wide;

  // Result register.
  logic                  out_valid_r;
  hlb_result_t           out_r;

  logic                  res_valid;
  hlb_result_t           res;
  logic                  out_free;
  logic                  fire;

  // The result register can take a new result when it is empty or its
  // current result leaves at this edge. The decode step only runs then,
  // so a character is never decoded without room for what it produces.
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;

  // The input register accepts a new character when it is empty or its current
  // one moves on in this cycle, so characters stream at one per cycle unless stalled.
  assign in_stall  = in_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  hlb_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .ch              (in_char_r),
    .phase           (phase_r),
    .high_nibble     (high_nibble_r),
    .pending         (pending_r),
    .count           (count_r),
    .limit           (limit_r),
    .phase_nxt       (phase_nxt),
    .high_nibble_nxt (high_nibble_nxt),
    .pending_nxt     (pending_nxt),
    .count_nxt       (count_nxt),
    .res_valid       (res_valid),
    .res             (res)
  );

  // A limit of zero behaves as one; anything past the counter range is capped.
  always_comb begin
    cfg_wide = {17'd0, cfg_data};
    if (cfg_wide == 33'd0) begin
      cfg_wide = 33'd1;
    end
    if (cfg_wide > CAP) begin
      cfg_wide = CAP;
    end
    limit_nxt = cfg_wide[COUNT_BITS-1:0];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_START;
      high_nibble_r <= 4'd0;
      pending_r     <= 1'b0;
      count_r       <= '0;
      limit_r       <= RST_LIMIT[COUNT_BITS-1:0];
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end

      if (fire && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (fire) begin
        phase_r       <= phase_nxt;
        high_nibble_r <= high_nibble_nxt;
        pending_r     <= pending_nxt;
        count_r       <= count_nxt;
      end

      if (cfg_valid && cfg_ready) begin
        limit_r <= limit_nxt;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char_r <= in_char;
    end
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_r.data;
  assign out_byte_valid   = out_r.data_valid;
  assign out_last         = out_r.last;
  assign out_status       = out_r.status;
  assign out_total_length = out_r.total_length;

endmodule

`default_nettype wire
